// ===== hw/rtl/multichannel_detection_fusion_macros.svh =====
// assertion macros for the multichannel detection fusion block
`ifndef MULTICHANNEL_DETECTION_FUSION_MACROS_SVH
`define MULTICHANNEL_DETECTION_FUSION_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define MDF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mdf assertion failed");
// consequent checked in the cycle after the antecedent
`define MDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdf sequencing assertion failed");
`else
`define MDF_ASSERT(lbl, clk, rst, prop)
`define MDF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/mdf_pkg.sv =====
// shared types and constants of the multichannel detection fusion block
`default_nettype none
package mdf_pkg;

  localparam int MAX_CH       = 4;
  localparam int NUM_CH_DEF   = 4;
  localparam int CAL_WINDOWS  = 3;
  localparam int LVL_W        = 16;
  localparam int PROB_W       = 16;
  localparam int MARGIN_W     = 14;
  localparam int ALPHA_W      = 16;
  localparam int WIN_W        = 4;
  localparam int CNT_W        = 3;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  // input word layout
  localparam int PROB_OFS     = MAX_CH * LVL_W;
  localparam int OK_OFS       = PROB_OFS + MAX_CH * PROB_W;
  localparam int IN_BITS      = OK_OFS + MAX_CH;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // output word layout
  localparam int OUT_BITS     = 2 + 2 * PROB_W + 2 * CNT_W + WIN_W;
  localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic signed [LVL_W-1:0] BASE_RESET = -16'sd30720;
  localparam logic [MARGIN_W-1:0] MARGIN_RST [MAX_CH] =
    '{14'd1280, 14'd1280, 14'd1024, 14'd1024};
  localparam logic [ALPHA_W-1:0] ALPHA_RISE_RST = 16'd39322;
  localparam logic [ALPHA_W-1:0] ALPHA_FALL_RST = 16'd9830;
  localparam logic [WIN_W-1:0]   PERSIST_RST    = 4'd3;
  localparam logic [WIN_W-1:0]   HOLD_RST       = 4'd3;

  // Q0.16 constants
  localparam logic [PROB_W-1:0] Q_W_TOP        = 16'd42598;
  localparam logic [PROB_W-1:0] Q_W_SECOND     = 16'd22938;
  localparam logic [PROB_W-1:0] Q_STRONG_TOP   = 16'd58982;
  localparam logic [PROB_W-1:0] Q_INSTANT      = 16'd39322;
  localparam logic [PROB_W-1:0] Q_TRIGGER      = 16'd55706;
  localparam logic [PROB_W-1:0] Q_SINGLE_WEAK  = 16'd26214;
  localparam logic [PROB_W-1:0] Q_SUSPICION    = 16'd16384;
  localparam logic [PROB_W-1:0] Q_WEAK_PRIMARY = 16'd19661;
  localparam logic [PROB_W-1:0] Q_WEAK_SUPPORT = 16'd9830;
  localparam logic [PROB_W-1:0] Q_FLOOR        = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARGIN0    = 4'd0,
    REG_MARGIN1    = 4'd1,
    REG_MARGIN2    = 4'd2,
    REG_MARGIN3    = 4'd3,
    REG_ALPHA_RISE = 4'd4,
    REG_ALPHA_FALL = 4'd5,
    REG_PERSIST    = 4'd6,
    REG_HOLD       = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ALERT_NONE = 2'd0,
    ALERT_NEAR = 2'd1,
    ALERT_FAR  = 2'd2,
    ALERT_HELD = 2'd3
  } alert_e;

  typedef struct packed {
    logic [MAX_CH-1:0][MARGIN_W-1:0] margin;
    logic [ALPHA_W-1:0]              alpha_rise;
    logic [ALPHA_W-1:0]              alpha_fall;
    logic [WIN_W-1:0]                persist_win;
    logic [WIN_W-1:0]                hold_win;
  } cfg_t;

  // classified window as it leaves the gating stage
  typedef struct packed {
    logic              calib;
    logic [CNT_W-1:0]  n_valid;
    logic [CNT_W-1:0]  n_active;
    logic [PROB_W-1:0] top;
    logic [PROB_W-1:0] second;
  } gate_t;

  typedef struct packed {
    gate_t             g;
    logic [PROB_W-1:0] fused;
  } q_rec_t;

  typedef struct packed {
    logic              calibrating;
    logic [WIN_W-1:0]  streak;
    logic [CNT_W-1:0]  n_active;
    logic [CNT_W-1:0]  n_valid;
    logic [PROB_W-1:0] smoothed;
    logic [PROB_W-1:0] fused;
    alert_e            alert;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/multichannel_detection_fusion.sv =====
// Multichannel detection fusion, one input word per one-second window.
// Slave stream s_*: four channel levels, four probabilities and four
// model-ok flags per word. Master stream m_*: one result word per input word,
// m_tuser high marks a calibration window (all m_tdata fields zero then).
// Config channel cfg_*: index 0..7 selects margins, alphas, persistence and
// hold; always ready; write only while no window is in flight.
// Path from input accept to m_tvalid: gating stage, queue, output register;
// a window with no valid channel also makes an extra pass through the single
// ema multiplier.
// Throughput: one word per cycle while m_tready does not stall the output;
// windows with no valid channel go slower, since the ema decay runs twice through the same multiplier.
// Reset: baselines return to -120 dB, the first three windows recalibrate,
// the ema, streak and hold clear and config registers take their defaults.
// A stalled m_tready holds the output word; the two-entry queue and the
// gating stage keep taking words until they fill, then s_tready drops.
`default_nettype none
`include "multichannel_detection_fusion_macros.svh"
module multichannel_detection_fusion
  import mdf_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // ch0..ch3 level_db, ch0..ch3 prob, ch0..ch3 model_ok, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // alert_level, fused_prob, smoothed_prob, valid_channels,
  // active_channels, streak_count, zero pad
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // calibrating
  output logic                       m_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   q_push;
  q_rec_t q_in;
  logic   q_full;
  logic   q_pop;
  q_rec_t q_rec;
  logic   q_valid;
  res_t   res;

  mdf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdf_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .q_push   (q_push),
    .q_rec    (q_in),
    .q_full   (q_full)
  );

  mdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_rec),
    .not_empty (q_valid)
  );

  mdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.calibrating;
  assign m_tdata = {(OUT_DATA_W-OUT_BITS)'(0), res.streak, res.n_active, res.n_valid,
                    res.smoothed, res.fused, res.alert};

  `MDF_ASSERT(a_calib_word_zero, clk, rst, m_tvalid && m_tuser |-> m_tdata == '0)
  `MDF_ASSERT(a_valid_within_active, clk, rst, m_tvalid |-> res.n_valid <= res.n_active)
  `MDF_ASSERT(a_silent_no_alert, clk, rst, m_tvalid && !m_tuser && res.n_valid == '0 |-> res.alert == ALERT_NONE && res.streak == '0)
  `MDF_ASSERT_NEXT(a_calib_passes_through, clk, rst, q_valid && q_rec.g.calib && !m_tvalid, m_tvalid && m_tuser)

endmodule
`default_nettype wire

// ===== hw/rtl/mdf_cfg.sv =====
// configuration register file
`default_nettype none
module mdf_cfg
  import mdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < MAX_CH; ch++) begin
        cfg.margin[ch] <= MARGIN_RST[ch];
      end
      cfg.alpha_rise  <= ALPHA_RISE_RST;
      cfg.alpha_fall  <= ALPHA_FALL_RST;
      cfg.persist_win <= PERSIST_RST;
      cfg.hold_win    <= HOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MARGIN0:    cfg.margin[0]   <= cfg_data[MARGIN_W-1:0];
        REG_MARGIN1:    cfg.margin[1]   <= cfg_data[MARGIN_W-1:0];
        REG_MARGIN2:    cfg.margin[2]   <= cfg_data[MARGIN_W-1:0];
        REG_MARGIN3:    cfg.margin[3]   <= cfg_data[MARGIN_W-1:0];
        REG_ALPHA_RISE: cfg.alpha_rise  <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_FALL: cfg.alpha_fall  <= cfg_data[ALPHA_W-1:0];
        REG_PERSIST:    cfg.persist_win <= cfg_data[WIN_W-1:0];
        REG_HOLD:       cfg.hold_win    <= cfg_data[WIN_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mdf_front.sv =====
// front end: calibration, baseline gating, top-two selection and fusion
`default_nettype none
module mdf_front
  import mdf_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  cfg_t                      cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IN_DATA_W-1:0] in_data,
  output logic                      q_push,
  output q_rec_t                    q_rec,
  input  wire logic                 q_full
);

  localparam int STORE_DEPTH = CAL_WINDOWS - 1;
  localparam int STORE_IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic signed [LVL_W-1:0] lvl [MAX_CH];
  logic [PROB_W-1:0]       prob [MAX_CH];
  logic [MAX_CH-1:0]       ok;

  logic signed [LVL_W-1:0] calib_store [NUM_CHANNELS][STORE_DEPTH];
  logic signed [LVL_W-1:0] baseline_level [NUM_CHANNELS];
  logic [1:0]              calib_count;
  logic                    baseline_frozen;

  logic  s1_valid;
  gate_t s1;
  gate_t gate_next;
  logic  accept;

  logic [PROB_W*2:0] mix_sum;

  function automatic logic signed [LVL_W-1:0] mid3(
    input logic signed [LVL_W-1:0] a_in,
    input logic signed [LVL_W-1:0] b_in,
    input logic signed [LVL_W-1:0] c_in
  );
    logic signed [LVL_W-1:0] a;
    logic signed [LVL_W-1:0] b;
    logic signed [LVL_W-1:0] c;
    logic signed [LVL_W-1:0] t;
    a = a_in;
    b = b_in;
    c = c_in;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    return b;
  endfunction

  always_comb begin
    for (int ch = 0; ch < MAX_CH; ch++) begin
      lvl[ch]  = in_data[ch*LVL_W +: LVL_W];
      prob[ch] = in_data[PROB_OFS + ch*PROB_W +: PROB_W];
      ok[ch]   = in_data[OK_OFS + ch];
    end
  end

  assign in_ready = !s1_valid || !q_full;
  assign accept   = in_valid && in_ready;

  // gate each channel against its frozen baseline, keep the two best probabilities
  always_comb begin
    logic signed [LVL_W:0] delta;
    gate_next = '0;
    delta     = '0;
    if (!baseline_frozen) begin
      gate_next.calib = 1'b1;
    end else begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        delta = {lvl[ch][LVL_W-1], lvl[ch]} -
                {baseline_level[ch][LVL_W-1], baseline_level[ch]};
        if (delta >= $signed({{(LVL_W+1-MARGIN_W){1'b0}}, cfg.margin[ch]})) begin
          gate_next.n_active = gate_next.n_active + CNT_W'(1);
          if (ok[ch]) begin
            gate_next.n_valid = gate_next.n_valid + CNT_W'(1);
            if (prob[ch] > gate_next.top) begin
              gate_next.second = gate_next.top;
              gate_next.top    = prob[ch];
            end else if (prob[ch] > gate_next.second) begin
              gate_next.second = prob[ch];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      calib_count     <= '0;
      baseline_frozen <= 1'b0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        baseline_level[ch] <= BASE_RESET;
      end
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (accept && !baseline_frozen) begin
        if (calib_count < 2'(CAL_WINDOWS - 1)) begin
          calib_count <= calib_count + 2'd1;
        end else begin
          for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            baseline_level[ch] <= mid3(calib_store[ch][0], calib_store[ch][1], lvl[ch]);
          end
          baseline_frozen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= gate_next;
      if (!baseline_frozen && (calib_count < 2'(CAL_WINDOWS - 1))) begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          calib_store[ch][calib_count[STORE_IDX_W-1:0]] <= lvl[ch];
        end
      end
    end
  end

  // 0.65 / 0.35 blend, rounded half up
  assign mix_sum = (PROB_W*2+1)'(Q_W_TOP * s1.top) +
                   (PROB_W*2+1)'(Q_W_SECOND * s1.second) +
                   (PROB_W*2+1)'(32768);

  always_comb begin
    q_rec.g = s1;
    if (s1.n_valid >= CNT_W'(2)) begin
      q_rec.fused = mix_sum[PROB_W*2-1:PROB_W];
    end else if (s1.n_valid == CNT_W'(1)) begin
      q_rec.fused = s1.top;
    end else begin
      q_rec.fused = '0;
    end
  end

  assign q_push = s1_valid && !q_full;

endmodule
`default_nettype wire

// ===== hw/rtl/mdf_queue.sv =====
// short queue between the front and back ends
`default_nettype none
module mdf_queue
  import mdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  q_rec_t    din,
  output logic      full,
  input  wire logic pop,
  output q_rec_t    dout,
  output logic      not_empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  q_rec_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full      = (count == CNT_QW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_QW'(1);
        2'b01:   count <= count - CNT_QW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mdf_back.sv =====
// back end: ema, weak streak, alert hold and the output register
`default_nettype none
module mdf_back
  import mdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic q_valid,
  input  q_rec_t    q_rec,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res
);

  logic [PROB_W-1:0] ema_value;
  logic [WIN_W-1:0]  weak_streak;
  logic [WIN_W-1:0]  hold_count;
  logic              decay_pass;
  logic              o_valid;

  logic [PROB_W-1:0]  target;
  logic [ALPHA_W-1:0] alpha;
  logic [PROB_W-1:0]  mix;
  logic               decay_item;
  logic               can_out;
  logic               first_pass;
  logic               finish;

  logic [PROB_W-1:0] ema_next;
  logic [WIN_W-1:0]  streak_next;
  logic [WIN_W-1:0]  hold_next;
  res_t              res_next;

  // old + a*(target - old), rounded half up; one multiplier
  function automatic logic [PROB_W-1:0] ema_mix(
    input logic [PROB_W-1:0]  old,
    input logic [PROB_W-1:0]  tgt,
    input logic [ALPHA_W-1:0] a
  );
    logic signed [PROB_W:0]     diff;
    logic signed [2*PROB_W+1:0] prod;
    logic [2*PROB_W+1:0]        s;
    diff = $signed({1'b0, tgt}) - $signed({1'b0, old});
    prod = $signed({1'b0, a}) * diff;
    s    = {2'b00, old, {PROB_W{1'b0}}} + prod + (2*PROB_W+2)'(32768);
    return s[2*PROB_W-1:PROB_W];
  endfunction

  assign decay_item = !q_rec.g.calib && (q_rec.g.n_valid == '0);
  assign target     = decay_pass ? '0 : q_rec.fused;
  assign alpha      = (target > ema_value) ? cfg.alpha_rise : cfg.alpha_fall;
  assign mix        = ema_mix(ema_value, target, alpha);
  assign can_out    = !o_valid || out_ready;
  // a window with no valid channel takes a second decay step
  assign first_pass = q_valid && decay_item && !decay_pass;
  assign finish     = q_valid && can_out && (!decay_item || decay_pass);
  assign q_pop      = finish;
  assign out_valid  = o_valid;

  always_comb begin
    logic [WIN_W-1:0] persist;
    logic             strong_hit;
    logic             near_hit;
    logic             weak_hit;
    logic             far_hit;
    persist    = (cfg.persist_win == '0) ? WIN_W'(1) : cfg.persist_win;
    strong_hit = (q_rec.g.n_valid >= CNT_W'(1)) && (q_rec.g.top >= Q_STRONG_TOP) &&
                 (q_rec.fused >= Q_INSTANT);
    near_hit   = strong_hit && (mix >= Q_TRIGGER);
    if (q_rec.g.n_valid >= CNT_W'(2)) begin
      weak_hit = (q_rec.g.top >= Q_WEAK_PRIMARY) && (q_rec.g.second >= Q_WEAK_SUPPORT) &&
                 (q_rec.fused >= Q_SUSPICION);
    end else if (q_rec.g.n_valid == CNT_W'(1)) begin
      weak_hit = (q_rec.g.top >= Q_SINGLE_WEAK) && (q_rec.fused >= Q_SUSPICION);
    end else begin
      weak_hit = 1'b0;
    end

    res_next          = '0;
    res_next.fused    = q_rec.fused;
    res_next.n_valid  = q_rec.g.n_valid;
    res_next.n_active = q_rec.g.n_active;
    res_next.alert    = ALERT_NONE;
    far_hit           = 1'b0;

    priority if (q_rec.g.calib) begin
      ema_next             = '0;
      streak_next          = '0;
      hold_next            = '0;
      res_next             = '0;
      res_next.calibrating = 1'b1;
    end else if (decay_item) begin
      ema_next    = (mix < Q_FLOOR) ? '0 : mix;
      streak_next = '0;
      hold_next   = '0;
    end else begin
      ema_next = mix;
      if (weak_hit) begin
        streak_next = (weak_streak < persist) ? weak_streak + WIN_W'(1) : weak_streak;
      end else begin
        streak_next = '0;
      end
      far_hit = (streak_next >= persist);
      if (near_hit || far_hit) begin
        hold_next = cfg.hold_win;
      end else if (hold_count != '0) begin
        hold_next = hold_count - WIN_W'(1);
      end else begin
        hold_next = '0;
      end
      priority if (near_hit) begin
        res_next.alert = ALERT_NEAR;
      end else if (far_hit) begin
        res_next.alert = ALERT_FAR;
      end else if (hold_next != '0) begin
        res_next.alert = ALERT_HELD;
      end else begin
        res_next.alert = ALERT_NONE;
      end
    end

    if (!q_rec.g.calib) begin
      res_next.smoothed = ema_next;
      res_next.streak   = streak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_value   <= '0;
      weak_streak <= '0;
      hold_count  <= '0;
      decay_pass  <= 1'b0;
      o_valid     <= 1'b0;
    end else begin
      if (first_pass) begin
        ema_value  <= mix;
        decay_pass <= 1'b1;
      end else if (finish) begin
        ema_value   <= ema_next;
        weak_streak <= streak_next;
        hold_count  <= hold_next;
        decay_pass  <= 1'b0;
      end
      if (finish) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire
